@@ rtl/pric_pkg.sv @@
`timescale 1ns / 1ps

package pric_pkg;

   // Default geometry of the polygon store.
   localparam int MAX_VERTICES = 8;
   localparam int COORD_BITS   = 12;

   // Fixed field widths.
   localparam int POS_W      = 12;
   localparam int NUM_REGION = 7;
   localparam int NUM_BIN    = 12;
   localparam int CNT_W      = 16;
   localparam int PCT_W      = 7;
   localparam int DVD_W      = 19;

   // Hit code used when no region is hit.
   localparam logic [2:0] NO_HIT = 3'd7;
   localparam logic [2:0] REGION_HEIGHT = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_COUNTS = 2'd2;

   // Object classes.
   localparam logic [1:0] CLS_PERSON = 2'd0;
   localparam logic [1:0] CLS_GUIDE  = 2'd1;
   localparam logic [1:0] CLS_SIGN   = 2'd2;
   localparam logic [1:0] CLS_OTHER  = 2'd3;

   // Sequencer states.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_WALK  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

endpackage

@@ rtl/polygon_region_intrusion_counter.sv @@
`timescale 1ns / 1ps

// Polygon region intrusion counter.
// Transactions on the req_ channel either load one polygon vertex (req_kind 0)
// or classify one object foot point (req_kind 1). Each object gives exactly one
// rsp_ transaction: the first enabled region hit, its saturating counter after
// the increment, and for region 4 the foot height as a percentage.
// The csr_ channel writes region_enable, image_height and vertex_counts; it is
// always ready. The user must write it only while the block is idle; the block
// itself does not enforce this. A load completes in the cycle it is accepted.
// An object walks its candidate regions in order: it selects each region,
// then tests one polygon edge per cycle through the single read port of the
// vertex memory and a two-stage multiply and compare. A hit in region 4 adds
// a bit-serial division.
// The result sits in an output register, so the next transaction is accepted
// while a result still waits; a second result waits until the first is taken.
// Reset clears counters, region_enable, vertex_counts and control, and sets
// image_height to 1080; the vertex memory is undefined until loaded.
module polygon_region_intrusion_counter #(
   parameter int MAX_VERTICES = pric_pkg::MAX_VERTICES,
   parameter int COORD_BITS   = pric_pkg::COORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [2:0]  req_region,
   input  logic [2:0]  req_vertex_index,
   input  logic [pric_pkg::POS_W-1:0] req_pos_x,
   input  logic [pric_pkg::POS_W-1:0] req_pos_y,
   input  logic [1:0]  req_object_class,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_hit_region,
   output logic [15:0] rsp_bin_count,
   output logic [6:0]  rsp_height_percent,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [27:0] csr_data
);

   localparam int PW     = pric_pkg::POS_W;
   localparam int DEPTH  = pric_pkg::NUM_REGION * MAX_VERTICES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [PW-1:0] CMASK = PW'((64'd1 << COORD_BITS) - 64'd1);

   // Configuration registers.
   logic [6:0]  enable_ff;
   logic [11:0] height_ff;
   logic [27:0] counts_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         height_ff <= 12'd1080;
         counts_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            pric_pkg::CSR_ENABLE: enable_ff <= csr_data[6:0];
            pric_pkg::CSR_HEIGHT: height_ff <= csr_data[11:0];
            pric_pkg::CSR_COUNTS: counts_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Control registers.
   pric_pkg::state_type state_ff, state_in;
   logic [2:0]  reg_ff, reg_in;
   logic [2:0]  last_ff, last_in;
   logic [1:0]  cls_ff, cls_in;
   logic [PW-1:0] px_ff, px_in, py_ff, py_in;
   logic [3:0]  k_ff, k_in;
   logic        parity_ff, parity_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic [12:0] rem_ff, rem_in;
   logic [pric_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [2:0]  hit_ff, hit_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [6:0]  pct_ff, pct_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_hit_ff, rsp_hit_in;
   logic [15:0] rsp_cnt_ff, rsp_cnt_in;
   logic [6:0]  rsp_pct_ff, rsp_pct_in;
   logic [15:0] bins_ff [pric_pkg::NUM_BIN];

   // Vertex memory and read pipeline.
   logic [2*PW-1:0] mem [DEPTH];
   logic [2*PW-1:0] rdata_ff;
   logic            s1_v_ff, s1_first_ff;
   logic            s2_v_ff, s2_cond_ff, s2_pos_ff;
   logic signed [2*PW+1:0] s2_num_ff, s2_lhs_ff;
   logic [PW-1:0]   prev_x_ff, prev_y_ff;

   logic            acc, rd_en, wr_en, bin_upd, clear_bins;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [3:0]      n_cur, vsel;
   logic [3:0]      bin_sel;

   assign acc = req_valid && req_ready;
   assign req_ready = (state_ff == pric_pkg::ST_IDLE);

   // Vertex count of the current region, clamped to the store depth.
   always_comb begin
      logic [3:0] nib;
      nib = 4'(counts_ff >> {reg_ff, 2'b00});
      n_cur = (32'(nib) > MAX_VERTICES) ? 4'(MAX_VERTICES) : nib;
   end

   assign vsel    = (k_ff == 4'd0) ? n_cur - 4'd1 : k_ff - 4'd1;
   assign rd_addr = ADDR_W'(32'(reg_ff) * MAX_VERTICES + 32'(vsel));
   assign wr_addr = ADDR_W'(32'(req_region) * MAX_VERTICES + 32'(req_vertex_index));
   assign wr_en   = acc && !req_kind && (req_region < 3'(pric_pkg::NUM_REGION))
                    && (32'(req_vertex_index) < MAX_VERTICES);
   assign rd_en   = (state_ff == pric_pkg::ST_WALK);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req_pos_x & CMASK, req_pos_y & CMASK};
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Edge test, first stage: crossing condition and the two products.
   logic [PW-1:0] cur_x, cur_y;
   logic signed [PW:0] den, dx, dy, dp;
   assign cur_x = rdata_ff[2*PW-1:PW];
   assign cur_y = rdata_ff[PW-1:0];
   assign den   = $signed({1'b0, prev_y_ff}) - $signed({1'b0, cur_y});
   assign dx    = $signed({1'b0, prev_x_ff}) - $signed({1'b0, cur_x});
   assign dy    = $signed({1'b0, py_ff}) - $signed({1'b0, cur_y});
   assign dp    = $signed({1'b0, px_ff}) - $signed({1'b0, cur_x});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= rd_en;
         s2_v_ff <= s1_v_ff && !s1_first_ff;
      end
      s1_first_ff <= (k_ff == 4'd0);
      if (s1_v_ff) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
      s2_cond_ff <= (cur_y > py_ff) != (prev_y_ff > py_ff);
      s2_pos_ff  <= (den > 0);
      s2_num_ff  <= dx * dy;
      s2_lhs_ff  <= dp * den;
   end

   // Second stage: compare and flip the parity.
   logic edge_cross;
   assign edge_cross = s2_pos_ff ? (s2_lhs_ff < s2_num_ff) : (s2_lhs_ff > s2_num_ff);

   assign bin_sel = (cls_ff == pric_pkg::CLS_PERSON) ? {1'b0, reg_ff} : {1'b0, reg_ff} + 4'd5;

   // Sequencer.
   always_comb begin
      logic [12:0] trial;
      logic [pric_pkg::DVD_W-1:0] q;
      state_in     = state_ff;
      reg_in       = reg_ff;
      last_in      = last_ff;
      cls_in       = cls_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      k_in         = k_ff;
      parity_in    = parity_ff;
      div_cnt_in   = div_cnt_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      hit_in       = hit_ff;
      cnt_in       = cnt_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_pct_in   = rsp_pct_ff;
      bin_upd      = 1'b0;
      clear_bins   = 1'b0;
      trial        = '0;
      q            = '0;
      if (s2_v_ff && s2_cond_ff && edge_cross) begin
         parity_in = !parity_ff;
      end
      unique case (state_ff)
         pric_pkg::ST_IDLE: begin
            if (acc && req_kind) begin
               clear_bins = req_frame_start;
               cls_in = req_object_class;
               px_in  = req_pos_x & CMASK;
               py_in  = req_pos_y & CMASK;
               hit_in = pric_pkg::NO_HIT;
               cnt_in = '0;
               pct_in = '0;
               if (req_object_class == pric_pkg::CLS_SIGN) begin
                  reg_in  = 3'd5;
                  last_in = 3'd6;
               end else begin
                  reg_in  = 3'd0;
                  last_in = 3'd4;
               end
               state_in = (req_object_class == pric_pkg::CLS_OTHER) ?
                          pric_pkg::ST_OUT : pric_pkg::ST_SCAN;
            end
         end
         pric_pkg::ST_SCAN: begin
            if (reg_ff > last_ff) begin
               state_in = pric_pkg::ST_OUT;
            end else if (enable_ff[reg_ff] && n_cur != 4'd0) begin
               k_in      = '0;
               parity_in = 1'b0;
               state_in  = pric_pkg::ST_WALK;
            end else begin
               reg_in = reg_ff + 3'd1;
            end
         end
         pric_pkg::ST_WALK: begin
            k_in = k_ff + 4'd1;
            if (k_ff == n_cur) begin
               state_in = pric_pkg::ST_DRAIN;
            end
         end
         pric_pkg::ST_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               if (parity_ff) begin
                  bin_upd = 1'b1;
                  hit_in  = reg_ff;
                  cnt_in  = (bins_ff[bin_sel] == 16'hFFFF) ? 16'hFFFF : bins_ff[bin_sel] + 16'd1;
                  if (reg_ff == pric_pkg::REGION_HEIGHT) begin
                     if (height_ff == 12'd0) begin
                        pct_in   = 7'd100;
                        state_in = pric_pkg::ST_OUT;
                     end else begin
                        dvd_in     = pric_pkg::DVD_W'(32'(py_ff) * 100);
                        rem_in     = '0;
                        div_cnt_in = '0;
                        state_in   = pric_pkg::ST_DIV;
                     end
                  end else begin
                     state_in = pric_pkg::ST_OUT;
                  end
               end else begin
                  reg_in   = reg_ff + 3'd1;
                  state_in = pric_pkg::ST_SCAN;
               end
            end
         end
         pric_pkg::ST_DIV: begin
            // One quotient bit per cycle, restoring division.
            if (div_cnt_ff == 5'(pric_pkg::DVD_W)) begin
               q = dvd_ff;
               if (q == '0) begin
                  pct_in = 7'd1;
               end else if (q > pric_pkg::DVD_W'(100)) begin
                  pct_in = 7'd100;
               end else begin
                  pct_in = 7'(q);
               end
               state_in = pric_pkg::ST_OUT;
            end else begin
               trial = {rem_ff[11:0], dvd_ff[pric_pkg::DVD_W-1]};
               if (trial >= {1'b0, height_ff}) begin
                  rem_in = trial - {1'b0, height_ff};
                  dvd_in = {dvd_ff[pric_pkg::DVD_W-2:0], 1'b1};
               end else begin
                  rem_in = trial;
                  dvd_in = {dvd_ff[pric_pkg::DVD_W-2:0], 1'b0};
               end
               div_cnt_in = div_cnt_ff + 5'd1;
            end
         end
         pric_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_cnt_in   = cnt_ff;
               rsp_pct_in   = pct_ff;
               state_in     = pric_pkg::ST_IDLE;
            end
         end
         default: state_in = pric_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pric_pkg::ST_IDLE;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         div_cnt_ff   <= '0;
         reg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         div_cnt_ff   <= div_cnt_in;
         reg_ff       <= reg_in;
      end
      last_ff    <= last_in;
      cls_ff     <= cls_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      hit_ff     <= hit_in;
      cnt_ff     <= cnt_in;
      pct_ff     <= pct_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_pct_ff <= rsp_pct_in;
   end

   // Hit counters: cleared at reset and when an object arrives with req_frame_start.
   always_ff @(posedge clock) begin
      if (reset || clear_bins) begin
         for (int b = 0; b < pric_pkg::NUM_BIN; b++) begin
            bins_ff[b] <= '0;
         end
      end else if (bin_upd) begin
         bins_ff[bin_sel] <= cnt_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit_region     = rsp_hit_ff;
   assign rsp_bin_count      = rsp_cnt_ff;
   assign rsp_height_percent = rsp_pct_ff;

endmodule

@@ rtl/pric_checker.sv @@
`timescale 1ns / 1ps

module pric_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_hit_region,
   input logic [15:0] rsp_bin_count,
   input logic [6:0]  rsp_height_percent
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped before acceptance");

   // A miss reports no count and no height.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_region == pric_pkg::NO_HIT |->
         rsp_bin_count == 16'd0 && rsp_height_percent == 7'd0)
      else $error("miss carries a count or a height");

   // A hit always counts at least once.
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_region != pric_pkg::NO_HIT |-> rsp_bin_count != 16'd0)
      else $error("hit with zero count");

   // Height only comes with region 4, and then lies in 1..100.
   a_height: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_height_percent != 7'd0 |->
         rsp_hit_region == pric_pkg::REGION_HEIGHT && rsp_height_percent <= 7'd100)
      else $error("height percentage out of place or range");

endmodule

bind polygon_region_intrusion_counter pric_checker u_pric_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_hit_region     (rsp_hit_region),
   .rsp_bin_count      (rsp_bin_count),
   .rsp_height_percent (rsp_height_percent)
);
